@@ sv/e2q_pkg.sv @@
// Package for the Euler-angle to quaternion converter.
// Holds widths, CORDIC constants and the arctangent table; no dependencies.
`default_nettype none
package e2q_pkg;
  localparam int ANGLE_WIDTH  = 16;
  localparam int QUAT_WIDTH   = 16;
  localparam int CORDIC_STEPS = 16;

  // CORDIC datapath: 32 fraction bits, values stay within about +/-2.
  localparam int ZW = 36;
  localparam int XW = 35;
  // Cos/sin and their rounded pair products at 30 fraction bits. Plus one
  // itself must be representable, so one bit above the sign is kept.
  localparam int TW = 32;

  localparam logic signed [ZW-1:0] PI_Q32      = 36'sd13493037704;
  localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_INV    = 35'sd2608131496;

  typedef logic signed [ZW-1:0] zval_t;
  typedef logic signed [XW-1:0] xval_t;
  typedef logic signed [TW-1:0] trig_t;

  // atan(2^-i) with 32 fraction bits.
  function automatic zval_t atan_q32(input logic [4:0] i);
    zval_t r;
    case (i)
      5'd0:  r = 36'sd3373259426;
      5'd1:  r = 36'sd1991351318;
      5'd2:  r = 36'sd1052175346;
      5'd3:  r = 36'sd534100635;
      5'd4:  r = 36'sd268086748;
      5'd5:  r = 36'sd134174063;
      5'd6:  r = 36'sd67103403;
      5'd7:  r = 36'sd33553749;
      5'd8:  r = 36'sd16777131;
      5'd9:  r = 36'sd8388597;
      5'd10: r = 36'sd4194303;
      5'd11: r = 36'sd2097152;
      5'd12: r = 36'sd1048576;
      5'd13: r = 36'sd524288;
      5'd14: r = 36'sd262144;
      5'd15: r = 36'sd131072;
      5'd16: r = 36'sd65536;
      5'd17: r = 36'sd32768;
      5'd18: r = 36'sd16384;
      5'd19: r = 36'sd8192;
      5'd20: r = 36'sd4096;
      5'd21: r = 36'sd2048;
      5'd22: r = 36'sd1024;
      5'd23: r = 36'sd512;
      5'd24: r = 36'sd256;
      5'd25: r = 36'sd128;
      5'd26: r = 36'sd64;
      5'd27: r = 36'sd32;
      5'd28: r = 36'sd16;
      5'd29: r = 36'sd8;
      5'd30: r = 36'sd4;
      5'd31: r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/e2q_cordic.sv @@
// Pipelined rotation-mode CORDIC: cosine and sine of half an angle.
// One stage per iteration plus fold and rounding stages; uses e2q_pkg.
`default_nettype none
module e2q_cordic import e2q_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle,
  output trig_t                              cos_o,
  output trig_t                              sin_o
);
  // The last iteration has no use for its residual angle, so z stops one short.
  zval_t z_r [CORDIC_STEPS];
  xval_t x_r [CORDIC_STEPS+1];
  xval_t y_r [CORDIC_STEPS+1];
  logic  flip_r [CORDIC_STEPS+1];
  trig_t cos_r, sin_r;
  zval_t z0;

  // Angle with 32-(ANGLE_WIDTH-3)+... : a * 2^(34-ANGLE_WIDTH) is a/2 at Q.32.
  assign z0 = zval_t'(angle) <<< (34 - ANGLE_WIDTH);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_INV;
      y_r[0] <= '0;
      if (z0 > HALF_PI_Q32) begin
        z_r[0] <= z0 - PI_Q32;
        flip_r[0] <= 1'b1;
      end else if (z0 < -HALF_PI_Q32) begin
        z_r[0] <= z0 + PI_Q32;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
      end
    end
    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          if (z_r[i] >= 0) begin
            z_r[i+1] <= z_r[i] - atan_q32(5'(i));
          end else begin
            z_r[i+1] <= z_r[i] + atan_q32(5'(i));
          end
        end
      end
    end
  end

  xval_t xf, yf, xr, yr;
  assign xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign xr = (xf + xval_t'(2)) >>> 2;
  assign yr = (yf + xval_t'(2)) >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xr[TW-1:0];
      sin_r <= yr[TW-1:0];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule
`default_nettype wire

@@ sv/e2q_combine.sv @@
// Quaternion assembly: pair products, triple products, sums, round, saturate.
// Four register stages; uses e2q_pkg.
`default_nettype none
module e2q_combine import e2q_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire trig_t                        cr, sr, cp, sp, cy, sy,
  output logic signed [4*QUAT_WIDTH-1:0]    quat_o
);
  localparam int PW = 2*TW;
  localparam int RS = 60 - (QUAT_WIDTH - 2);
  localparam int SW = PW + 1;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  // Stage 1: pair products cy*cr, cy*sr, sy*cr, sy*sr.
  prod_t pcc_r, pcs_r, psc_r, pss_r;
  trig_t cp1_r, sp1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r <= prod_t'(cy) * prod_t'(cr);
      pcs_r <= prod_t'(cy) * prod_t'(sr);
      psc_r <= prod_t'(sy) * prod_t'(cr);
      pss_r <= prod_t'(sy) * prod_t'(sr);
      cp1_r <= cp;
      sp1_r <= sp;
    end
  end

  // Stage 2: round pairs to 30 fraction bits.
  function automatic trig_t rnd30(input prod_t v);
    prod_t t;
    t = (v + (prod_t'(1) <<< 29)) >>> 30;
    return t[TW-1:0];
  endfunction
  trig_t acc_r, acs_r, asc_r, ass_r, cp2_r, sp2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= rnd30(pcc_r);
      acs_r <= rnd30(pcs_r);
      asc_r <= rnd30(psc_r);
      ass_r <= rnd30(pss_r);
      cp2_r <= cp1_r;
      sp2_r <= sp1_r;
    end
  end

  // Stage 3: eight triple products.
  prod_t t_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= prod_t'(acc_r) * prod_t'(cp2_r);
      t_r[1] <= prod_t'(ass_r) * prod_t'(sp2_r);
      t_r[2] <= prod_t'(acs_r) * prod_t'(cp2_r);
      t_r[3] <= prod_t'(asc_r) * prod_t'(sp2_r);
      t_r[4] <= prod_t'(acc_r) * prod_t'(sp2_r);
      t_r[5] <= prod_t'(ass_r) * prod_t'(cp2_r);
      t_r[6] <= prod_t'(asc_r) * prod_t'(cp2_r);
      t_r[7] <= prod_t'(acs_r) * prod_t'(sp2_r);
    end
  end

  // Stage 4: sum, round, saturate.
  function automatic logic [QUAT_WIDTH-1:0] fin(input sum_t v);
    sum_t r;
    r = (v + (sum_t'(1) <<< (RS-1))) >>> RS;
    if (r > (sum_t'(1) <<< (QUAT_WIDTH-2)))       r = sum_t'(1) <<< (QUAT_WIDTH-2);
    else if (r < -(sum_t'(1) <<< (QUAT_WIDTH-2))) r = -(sum_t'(1) <<< (QUAT_WIDTH-2));
    return r[QUAT_WIDTH-1:0];
  endfunction
  logic [4*QUAT_WIDTH-1:0] q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0*QUAT_WIDTH +: QUAT_WIDTH] <= fin(sum_t'(t_r[0]) + sum_t'(t_r[1]));
      q_r[1*QUAT_WIDTH +: QUAT_WIDTH] <= fin(sum_t'(t_r[2]) - sum_t'(t_r[3]));
      q_r[2*QUAT_WIDTH +: QUAT_WIDTH] <= fin(sum_t'(t_r[4]) + sum_t'(t_r[5]));
      q_r[3*QUAT_WIDTH +: QUAT_WIDTH] <= fin(sum_t'(t_r[6]) - sum_t'(t_r[7]));
    end
  end
  assign quat_o = q_r;
endmodule
`default_nettype wire

@@ sv/euler_to_quaternion.sv @@
// Euler angles (roll, pitch, yaw, ZYX order) to unit quaternion.
// Input words carry three Q3.13 angles in radians; output words carry
// w, x, y, z in Q2.14, each rounded and saturated to plus or minus one.
// Three pipelined CORDIC units form the half-angle cosines and sines, and
// a four-stage multiplier block forms and sums the triple products.
// One word is accepted every cycle unless a stalled receiver holds the pipeline.
// The whole pipeline advances only when its last stage is free or being
// drained, so a stalled receiver freezes every stage and nothing is lost.
// in_tready is high whenever the output register is empty or taken.
// Reset clears the valid bits only; data registers are not reset.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  input  wire logic [3*ANGLE_WIDTH-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  output logic [4*QUAT_WIDTH-1:0]       out_tdata
);
  localparam int LAT = CORDIC_STEPS + 6;

  logic [LAT-1:0] vld_r, vld_nxt;
  logic en;

  assign en        = out_tready | ~vld_r[LAT-1];
  assign in_tready = en;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  trig_t cr, sr, cp, sp, cy, sy;
  e2q_cordic u_roll  (.clk, .en, .angle(in_tdata[0*ANGLE_WIDTH +: ANGLE_WIDTH]),
                      .cos_o(cr), .sin_o(sr));
  e2q_cordic u_pitch (.clk, .en, .angle(in_tdata[1*ANGLE_WIDTH +: ANGLE_WIDTH]),
                      .cos_o(cp), .sin_o(sp));
  e2q_cordic u_yaw   (.clk, .en, .angle(in_tdata[2*ANGLE_WIDTH +: ANGLE_WIDTH]),
                      .cos_o(cy), .sin_o(sy));

  logic signed [4*QUAT_WIDTH-1:0] q;
  e2q_combine u_comb (.clk, .en, .cr, .sr, .cp, .sp, .cy, .sy, .quat_o(q));

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = q;

  // A held word must not be overwritten while the receiver stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held output word changed");
  // Components never exceed plus or minus one; this checks quat_w only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[QUAT_WIDTH-1:0]) <= (1 <<< (QUAT_WIDTH-2)))
      && ($signed(out_tdata[QUAT_WIDTH-1:0]) >= -(1 <<< (QUAT_WIDTH-2))))
    else $error("quat_w out of range");
  // The input side is ready whenever the output register is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled with empty output");
endmodule
`default_nettype wire
